>>> rtl/tpq_pkg.sv
// Shared types and constants for the touch point qualifier.
// No dependencies; imported by every module of the block.
package tpq_pkg;

   // Coordinate width default and panel size register width
   localparam int COORD_BITS_DEF = 10;
   localparam int PANEL_BITS     = 11;

   // Configuration register indexes
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROTATION     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PANEL_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PANEL_HEIGHT = 2'd2;

   // Rotation codes; the spare code maps as portrait
   localparam int ROT_BITS = 2;
   localparam logic [ROT_BITS-1:0] ROT_PORTRAIT = 2'd0;
   localparam logic [ROT_BITS-1:0] ROT_LAND_A   = 2'd1;
   localparam logic [ROT_BITS-1:0] ROT_LAND_B   = 2'd2;

   // Register reset values
   localparam logic [PANEL_BITS-1:0] PANEL_WIDTH_RST  = 11'd368;
   localparam logic [PANEL_BITS-1:0] PANEL_HEIGHT_RST = 11'd448;

   // Empty polls held as a press before release
   localparam int MISS_BITS = 2;
   localparam logic [MISS_BITS-1:0] MISS_LIMIT = 2'd2;

   typedef struct packed {
      logic [ROT_BITS-1:0]   rotation_mode;
      logic [PANEL_BITS-1:0] panel_width;
      logic [PANEL_BITS-1:0] panel_height;
   } cfg_type;

   typedef struct packed {
      logic pressed;
      logic wake_request;
      logic touch_active;
      logic held_on_miss;
   } qual_flags_type;

endpackage

>>> rtl/tpq_csr.sv
// Configuration registers of the touch point qualifier.
// Depends on tpq_pkg for register indexes, widths and reset values.
module tpq_csr
   import tpq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [PANEL_BITS-1:0]   csr_data,
   output cfg_type                 cfg
);

   cfg_type cfg_ff, cfg_in;

   // Always able to take a write
   assign csr_ready = 1'b1;

   // Register decode; unlisted indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROTATION:     cfg_in.rotation_mode = csr_data[ROT_BITS-1:0];
            CSR_PANEL_WIDTH:  cfg_in.panel_width   = csr_data;
            CSR_PANEL_HEIGHT: cfg_in.panel_height  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation_mode <= ROT_PORTRAIT;
         cfg_ff.panel_width   <= PANEL_WIDTH_RST;
         cfg_ff.panel_height  <= PANEL_HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/tpq_map.sv
// Rotation mapping and clamping of one raw touch point.
// Depends on tpq_pkg for the configuration struct and rotation codes.
module tpq_map
   import tpq_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  cfg_type               cfg,
   input  logic [COORD_BITS-1:0] raw_x,
   input  logic [COORD_BITS-1:0] raw_y,
   output logic [COORD_BITS-1:0] map_x,
   output logic [COORD_BITS-1:0] map_y
);

   // Wide enough for panel size minus raw coordinate, plus sign
   localparam int CALC_W = ((COORD_BITS > PANEL_BITS) ? COORD_BITS : PANEL_BITS) + 2;
   localparam logic signed [CALC_W-1:0] ONE_S = {{(CALC_W-1){1'b0}}, 1'b1};
   localparam logic signed [CALC_W-1:0] MAX_S =
      {{(CALC_W-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

   logic signed [CALC_W-1:0] pw_s, ph_s, rx_s, ry_s, mx_s, my_s;

   assign pw_s = {{(CALC_W-PANEL_BITS){1'b0}}, cfg.panel_width};
   assign ph_s = {{(CALC_W-PANEL_BITS){1'b0}}, cfg.panel_height};
   assign rx_s = {{(CALC_W-COORD_BITS){1'b0}}, raw_x};
   assign ry_s = {{(CALC_W-COORD_BITS){1'b0}}, raw_y};

   // Select mapping by rotation
   always_comb begin
      case (cfg.rotation_mode)
         ROT_LAND_A: begin
            mx_s = ry_s;
            my_s = pw_s - ONE_S - rx_s;
         end
         ROT_LAND_B: begin
            mx_s = ph_s - ONE_S - ry_s;
            my_s = rx_s;
         end
         default: begin
            mx_s = rx_s;
            my_s = ry_s;
         end
      endcase
   end

   // Negative goes to zero, oversize saturates
   function automatic logic [COORD_BITS-1:0] clamp(input logic signed [CALC_W-1:0] v);
      logic [COORD_BITS-1:0] r;
      if (v[CALC_W-1])   r = '0;
      else if (v > MAX_S) r = {COORD_BITS{1'b1}};
      else                r = v[COORD_BITS-1:0];
      return r;
   endfunction

   assign map_x = clamp(mx_s);
   assign map_y = clamp(my_s);

endmodule

>>> rtl/tpq_qual.sv
// Press qualification state: latched point, miss count, swallow and touched flags.
// Depends on tpq_pkg for the miss limit and the result flag struct.
module tpq_qual
   import tpq_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  touch_valid,
   input  logic                  screen_off,
   input  logic                  boot_swallow,
   input  logic [COORD_BITS-1:0] map_x,
   input  logic [COORD_BITS-1:0] map_y,
   output qual_flags_type        flags,
   output logic [COORD_BITS-1:0] point_x,
   output logic [COORD_BITS-1:0] point_y
);

   logic [MISS_BITS-1:0]  miss_ff, miss_in;
   logic [COORD_BITS-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic                  swallow_ff, swallow_in;
   logic                  touched_ff, touched_in;

   // Next state and flags for the request in the stage
   always_comb begin
      miss_in    = miss_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      touched_in = touched_ff;
      swallow_in = swallow_ff | (boot_swallow & touch_valid);
      flags      = '0;
      if (touch_valid) begin
         if (screen_off) begin
            flags.wake_request = 1'b1;
            swallow_in         = 1'b1;
         end
         if (!swallow_in) begin
            last_x_in     = map_x;
            last_y_in     = map_y;
            miss_in       = '0;
            touched_in    = 1'b1;
            flags.pressed = 1'b1;
         end
      end else if (touched_ff && (miss_ff < MISS_LIMIT)) begin
         // repeat last point over an empty poll
         miss_in            = miss_ff + 1'b1;
         flags.pressed      = 1'b1;
         flags.held_on_miss = 1'b1;
      end else begin
         miss_in    = '0;
         swallow_in = 1'b0;
         touched_in = 1'b0;
      end
      flags.touch_active = touched_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_ff    <= '0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         swallow_ff <= 1'b0;
         touched_ff <= 1'b0;
      end else if (advance) begin
         miss_ff    <= miss_in;
         last_x_ff  <= last_x_in;
         last_y_ff  <= last_y_in;
         swallow_ff <= swallow_in;
         touched_ff <= touched_in;
      end
   end

   assign point_x = last_x_in;
   assign point_y = last_y_in;

endmodule

>>> rtl/touch_point_qualifier_top.sv
// Top level of the touch point qualifier: request register, mapping, state, result register.
// Depends on tpq_pkg, tpq_csr, tpq_map and tpq_qual.
//
//   channel   handshake               payload
//   req       req_valid / req_ready   touch_valid, raw_x, raw_y, screen_off, boot_swallow
//   rsp       rsp_valid / rsp_ready   pressed, point_x, point_y, wake_request,
//                                     touch_active, held_on_miss
//   csr       csr_valid / csr_ready   csr_index, csr_data (write only)
//
// One request per cycle sustained while rsp_ready is held high; a taken request loads the request
// register, then moves into the result register once that is free or being emptied (mapping
// and state update sit between the two registers).
// Reset is synchronous: state and panel registers return to defaults, both stages empty.
// A stalled result holds the result register; the request register still drains into it
// in the same cycle the result is taken, so req_ready stays high through a rsp_ready pulse.
// csr_ready is always high.
module touch_point_qualifier_top
   import tpq_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_touch_valid,
   input  logic [COORD_BITS-1:0]   req_raw_x,
   input  logic [COORD_BITS-1:0]   req_raw_y,
   input  logic                    req_screen_off,
   input  logic                    req_boot_swallow,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_pressed,
   output logic [COORD_BITS-1:0]   rsp_point_x,
   output logic [COORD_BITS-1:0]   rsp_point_y,
   output logic                    rsp_wake_request,
   output logic                    rsp_touch_active,
   output logic                    rsp_held_on_miss,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [PANEL_BITS-1:0]   csr_data
);

   cfg_type               cfg;
   logic                  in_valid_ff, in_valid_in;
   logic                  in_touch_ff, in_scr_ff, in_boot_ff;
   logic [COORD_BITS-1:0] in_x_ff, in_y_ff;
   logic                  advance, req_fire;
   logic [COORD_BITS-1:0] map_x, map_y, point_x, point_y;
   qual_flags_type        flags;
   logic                  rsp_valid_ff, rsp_valid_in;
   qual_flags_type        rsp_flags_ff;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;

   tpq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Stage moves when the result register is free or being emptied
   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_fire  = req_valid & req_ready;

   // Request register
   assign in_valid_in = req_fire | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_touch_ff <= req_touch_valid;
         in_x_ff     <= req_raw_x;
         in_y_ff     <= req_raw_y;
         in_scr_ff   <= req_screen_off;
         in_boot_ff  <= req_boot_swallow;
      end
   end

   tpq_map #(.COORD_BITS(COORD_BITS)) u_map (
      .cfg   (cfg),
      .raw_x (in_x_ff),
      .raw_y (in_y_ff),
      .map_x (map_x),
      .map_y (map_y)
   );

   tpq_qual #(.COORD_BITS(COORD_BITS)) u_qual (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .touch_valid  (in_touch_ff),
      .screen_off   (in_scr_ff),
      .boot_swallow (in_boot_ff),
      .map_x        (map_x),
      .map_y        (map_y),
      .flags        (flags),
      .point_x      (point_x),
      .point_y      (point_y)
   );

   // Result register
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_flags_ff <= flags;
         rsp_x_ff     <= point_x;
         rsp_y_ff     <= point_y;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pressed      = rsp_flags_ff.pressed;
   assign rsp_point_x      = rsp_x_ff;
   assign rsp_point_y      = rsp_y_ff;
   assign rsp_wake_request = rsp_flags_ff.wake_request;
   assign rsp_touch_active = rsp_flags_ff.touch_active;
   assign rsp_held_on_miss = rsp_flags_ff.held_on_miss;

endmodule

>>> rtl/tpq_checker.sv
// Port-level checks for the touch point qualifier, bound to the top level.
// Depends on tpq_pkg and touch_point_qualifier_top.
module tpq_checker
   import tpq_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_pressed,
   input logic [COORD_BITS-1:0]   rsp_point_x,
   input logic [COORD_BITS-1:0]   rsp_point_y,
   input logic                    rsp_wake_request,
   input logic                    rsp_touch_active,
   input logic                    rsp_held_on_miss
);

   // A held point is always reported as a press
   a_held_is_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_held_on_miss |-> rsp_pressed)
      else $error("held_on_miss without pressed");

   // A wake touch is swallowed, never a press
   a_wake_swallowed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake_request |-> !rsp_pressed)
      else $error("wake_request together with pressed");

   // A press leaves the touched flag set
   a_press_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressed |-> rsp_touch_active)
      else $error("pressed without touch_active");

   // A stalled result keeps its point
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y))
      else $error("stalled result changed");

endmodule

bind touch_point_qualifier_top tpq_checker #(.COORD_BITS(COORD_BITS)) u_tpq_checker (.*);
